/* rtl/kts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_pkg: shared definitions of the key table search
// Table geometry, field widths, operation, mode and register codes.
// ----------------------------------------------------------------------------
package kts_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int KEY_WIDTH   = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);

   // fixed field widths
   localparam int IN_IDX_W    = 6;
   localparam int IN_KEY_W    = 32;
   localparam int POS_W       = 6;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 7;
   localparam int TLEN_W      = 7;
   localparam int MODE_W      = 2;

   // operation codes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // search modes
   localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LAST   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ALL    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_BINARY = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_MODE  = 1'b1;

   typedef logic signed [KEY_WIDTH-1:0] key_type;

endpackage

/* rtl/kts_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_req_if: request channel
// Carries write and search transactions into the key table search.
// ----------------------------------------------------------------------------
interface kts_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 operation;
   logic [kts_pkg::IN_IDX_W-1:0]         entry_index;
   logic signed [kts_pkg::IN_KEY_W-1:0]  entry_key;
   logic signed [kts_pkg::IN_KEY_W-1:0]  search_key;

   modport source (output valid, operation, entry_index, entry_key, search_key,
                   input ready);
   modport sink   (input valid, operation, entry_index, entry_key, search_key,
                   output ready);
endinterface

/* rtl/kts_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_rsp_if: response channel
// Carries search results out of the key table search.
// ----------------------------------------------------------------------------
interface kts_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [kts_pkg::POS_W-1:0]   position;
   logic                        last;

   modport source (output valid, found, position, last, input ready);
   modport sink   (input valid, found, position, last, output ready);
endinterface

/* rtl/kts_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module kts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/key_table_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_table_search: table of signed keys with configurable search
// Write transactions fill a key RAM; search transactions scan it first-match,
// last-match, all-matches or by bisection and return one or more results.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | contents
//  req_chan | in  | valid / ready | operation, entry_index, entry_key, search_key
//  rsp_chan | out | valid / ready | found, position, last
//  csr_*    | in  | csr_wr_en     | csr_index, csr_wr_data (table_length, search_mode)
//
//  A write is done in the idle state. A linear search reads one entry per cycle
//  from the key RAM unless a result waits on a full result register. A binary
//  search runs at most 7 bisection steps (read, compare) and ends a miss in S_FIN.
//  Reset clears the configuration registers and the control; the datapath
//  registers and the key RAM are not cleared. A full result register stalls the
//  scan; a new transaction is taken once the last result of the search sits in the result register.
// ----------------------------------------------------------------------------
module key_table_search (
   input  logic                              clock,
   input  logic                              reset,
   kts_req_if.sink                           req_chan,
   kts_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [kts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kts_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   localparam int IDX_W = kts_pkg::IDX_W;
   localparam int LEN_W = kts_pkg::LEN_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LIN  = 3'd1;
   localparam logic [2:0] S_BRD  = 3'd2;
   localparam logic [2:0] S_BCMP = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0]                         state_ff, state_in;
   logic [kts_pkg::TLEN_W-1:0]         tlen_ff, tlen_in;
   logic [kts_pkg::MODE_W-1:0]         mode_ff, mode_in;
   logic [kts_pkg::MODE_W-1:0]         smode_ff, smode_in;
   kts_pkg::key_type                   key_ff, key_in;
   logic [IDX_W-1:0]                   iss_idx_ff, iss_idx_in;
   logic [LEN_W-1:0]                   iss_left_ff, iss_left_in;
   logic                               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]                   cmp_idx_ff, cmp_idx_in;
   logic                               prev_vld_ff, prev_vld_in;
   logic [IDX_W-1:0]                   prev_idx_ff, prev_idx_in;
   logic [LEN_W-1:0]                   lo_ff, lo_in;
   logic [LEN_W-1:0]                   hip_ff, hip_in;
   logic                               rsp_vld_ff, rsp_vld_in;
   logic                               found_ff, found_in;
   logic [kts_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic                               last_ff, last_in;

   logic                               ram_we;
   logic [IDX_W-1:0]                   ram_waddr;
   kts_pkg::key_type                   ram_wdata;
   logic [IDX_W-1:0]                   ram_raddr;
   kts_pkg::key_type                   ram_rdata;

   logic [LEN_W-1:0]                   len_sat;
   logic                               out_free;
   logic                               hit;
   logic                               hit_v;
   logic                               need_emit;
   logic [LEN_W:0]                     mid_sum;
   logic [IDX_W-1:0]                   mid;

   // key storage
   kts_ram #(
      .WIDTH (kts_pkg::KEY_WIDTH),
      .DEPTH (kts_pkg::TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // saturate the length and decode the compare
   assign len_sat   = (tlen_ff > kts_pkg::TLEN_W'(kts_pkg::TABLE_DEPTH))
                      ? LEN_W'(kts_pkg::TABLE_DEPTH) : LEN_W'(tlen_ff);
   assign out_free  = !rsp_vld_ff || rsp_chan.ready;
   assign hit       = (ram_rdata == key_ff);
   assign hit_v     = cmp_vld_ff && hit;
   assign need_emit = hit_v && ((smode_ff != kts_pkg::MODE_ALL) || prev_vld_ff);
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hip_ff} - (LEN_W + 1)'(1);
   assign mid       = IDX_W'(mid_sum >> 1);

   assign ram_waddr = IDX_W'(req_chan.entry_index);
   assign ram_wdata = kts_pkg::KEY_WIDTH'(req_chan.entry_key);

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = rsp_vld_ff;
   assign rsp_chan.found    = found_ff;
   assign rsp_chan.position = pos_ff;
   assign rsp_chan.last     = last_ff;

   // configuration registers
   always_comb begin
      tlen_in = tlen_ff;
      mode_in = mode_ff;
      if (csr_wr_en) begin
         case (csr_index)
            kts_pkg::CSR_TABLE_LENGTH: tlen_in = csr_wr_data[kts_pkg::TLEN_W-1:0];
            kts_pkg::CSR_SEARCH_MODE:  mode_in = csr_wr_data[kts_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // search sequencer
   always_comb begin
      logic [LEN_W-1:0] lo_nx;
      logic [LEN_W-1:0] hip_nx;
      logic             ld;
      logic             ld_found;
      logic [IDX_W-1:0] ld_idx;
      logic             ld_last;

      state_in    = state_ff;
      smode_in    = smode_ff;
      key_in      = key_ff;
      iss_idx_in  = iss_idx_ff;
      iss_left_in = iss_left_ff;
      cmp_vld_in  = cmp_vld_ff;
      cmp_idx_in  = cmp_idx_ff;
      prev_vld_in = prev_vld_ff;
      prev_idx_in = prev_idx_ff;
      lo_in       = lo_ff;
      hip_in      = hip_ff;
      ram_we      = 1'b0;
      ram_raddr   = iss_idx_ff;
      lo_nx       = lo_ff;
      hip_nx      = hip_ff;
      ld          = 1'b0;
      ld_found    = 1'b0;
      ld_idx      = '0;
      ld_last     = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.operation == kts_pkg::OP_WRITE) begin
                  ram_we = (req_chan.entry_index < kts_pkg::TABLE_DEPTH);
               end else begin
                  key_in      = kts_pkg::KEY_WIDTH'(req_chan.search_key);
                  smode_in    = mode_ff;
                  lo_in       = '0;
                  hip_in      = len_sat;
                  iss_left_in = len_sat;
                  iss_idx_in  = (mode_ff == kts_pkg::MODE_LAST)
                                ? IDX_W'(len_sat - LEN_W'(1)) : '0;
                  cmp_vld_in  = 1'b0;
                  prev_vld_in = 1'b0;
                  if (len_sat == '0) begin
                     state_in = S_FIN;
                  end else if (mode_ff == kts_pkg::MODE_BINARY) begin
                     state_in = S_BRD;
                  end else begin
                     state_in = S_LIN;
                  end
               end
            end
         end
         S_LIN: begin
            if (need_emit && !out_free) begin
               // hold: re-read the entry under compare
               ram_raddr = cmp_idx_ff;
            end else begin
               // advance the scan by one entry
               ram_raddr = iss_idx_ff;
               if (iss_left_ff != '0) begin
                  cmp_vld_in  = 1'b1;
                  cmp_idx_in  = iss_idx_ff;
                  iss_idx_in  = (smode_ff == kts_pkg::MODE_LAST)
                                ? iss_idx_ff - IDX_W'(1) : iss_idx_ff + IDX_W'(1);
                  iss_left_in = iss_left_ff - LEN_W'(1);
               end else begin
                  cmp_vld_in = 1'b0;
               end
               if (hit_v) begin
                  if (smode_ff == kts_pkg::MODE_ALL) begin
                     if (prev_vld_ff) begin
                        ld       = 1'b1;
                        ld_found = 1'b1;
                        ld_idx   = prev_idx_ff;
                        ld_last  = 1'b0;
                     end
                     prev_vld_in = 1'b1;
                     prev_idx_in = cmp_idx_ff;
                  end else begin
                     ld         = 1'b1;
                     ld_found   = 1'b1;
                     ld_idx     = cmp_idx_ff;
                     cmp_vld_in = 1'b0;
                     state_in   = S_IDLE;
                  end
               end else if (!cmp_vld_ff && (iss_left_ff == '0)) begin
                  state_in = S_FIN;
               end
            end
         end
         S_BRD: begin
            ram_raddr  = mid;
            cmp_idx_in = mid;
            state_in   = S_BCMP;
         end
         S_BCMP: begin
            ram_raddr = cmp_idx_ff;
            if (hit) begin
               if (out_free) begin
                  ld       = 1'b1;
                  ld_found = 1'b1;
                  ld_idx   = cmp_idx_ff;
                  state_in = S_IDLE;
               end
            end else begin
               // narrow the interval
               if (key_ff < ram_rdata) begin
                  hip_nx = LEN_W'(cmp_idx_ff);
               end else begin
                  lo_nx = LEN_W'(cmp_idx_ff) + LEN_W'(1);
               end
               lo_in    = lo_nx;
               hip_in   = hip_nx;
               state_in = (lo_nx < hip_nx) ? S_BRD : S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               ld = 1'b1;
               if ((smode_ff == kts_pkg::MODE_ALL) && prev_vld_ff) begin
                  ld_found = 1'b1;
                  ld_idx   = prev_idx_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // result register
      found_in   = ld ? ld_found : found_ff;
      pos_in     = ld ? kts_pkg::POS_W'(ld_idx) : pos_ff;
      last_in    = ld ? ld_last : last_ff;
      rsp_vld_in = ld ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_vld_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         tlen_ff    <= '0;
         mode_ff    <= kts_pkg::MODE_FIRST;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tlen_ff    <= tlen_in;
         mode_ff    <= mode_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      smode_ff    <= smode_in;
      key_ff      <= key_in;
      iss_idx_ff  <= iss_idx_in;
      iss_left_ff <= iss_left_in;
      cmp_idx_ff  <= cmp_idx_in;
      prev_vld_ff <= prev_vld_in;
      prev_idx_ff <= prev_idx_in;
      lo_ff       <= lo_in;
      hip_ff      <= hip_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      last_ff     <= last_in;
   end

   // checks
   a_search_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.operation == kts_pkg::OP_SEARCH))
      |=> !req_chan.ready)
      else $error("search accepted but channel stayed ready");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_LIN) && cmp_vld_ff) |-> (LEN_W'(cmp_idx_ff) < len_sat))
      else $error("scan compared an entry beyond the table length");

   a_bisect_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BRD) |-> (lo_ff < hip_ff))
      else $error("bisection read with an empty interval");

   a_partial_all_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !last_ff) |-> (smode_ff == kts_pkg::MODE_ALL))
      else $error("non-final result outside all-matches mode");

endmodule
